// ----- sv/phbsc_pkg.sv -----
// Package for the host bridge configuration space: request kinds, back-end
// states, register offsets, write masks and the reset image of the store.
// No dependencies.
`timescale 1ns / 1ps

package phbsc_pkg;

  localparam logic [7:0] ID_HI           = 8'h03;
  localparam logic [7:0] CMD_LO_REG      = 8'h04;
  localparam logic [7:0] CMD_HI_REG      = 8'h05;
  localparam logic [7:0] STATUS_LO_REG   = 8'h06;
  localparam logic [7:0] STATUS_HI_REG   = 8'h07;
  localparam logic [7:0] HDR_LO          = 8'h08;
  localparam logic [7:0] HDR_HI          = 8'h0C;
  localparam logic [7:0] BIST_REG        = 8'h0E;
  localparam logic [7:0] MODE_REG        = 8'h53;
  localparam logic [7:0] SHADOW_REG      = 8'h54;
  localparam logic [7:0] RSV_LO          = 8'h10;
  localparam logic [7:0] RSV_HI          = 8'h4E;
  localparam logic [7:0] CMD_LO_MASK     = 8'h42;
  localparam logic [7:0] CMD_LO_FORCE    = 8'h04;
  localparam logic [7:0] CMD_HI_MASK     = 8'h01;
  localparam logic [7:0] STATUS_LO_FORCE = 8'h00;
  localparam logic [7:0] STATUS_HI_FORCE = 8'h02;
  localparam logic [7:0] SHADOW_KEEP     = 8'hF0;
  localparam logic [7:0] NO_FUNC_DATA    = 8'hFF;
  localparam logic [1:0] FIFO_DEPTH      = 2'd2;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_READ,
    CMD_READ_FF,
    CMD_WRITE,
    CMD_WRITE_MODE,
    CMD_WRITE_SHADOW
  } cmd_kind_e;

  typedef enum logic {
    BK_IDLE,
    BK_RDWAIT
  } back_state_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] addr;
    logic [7:0] data;
  } cmd_t;

  function automatic logic [7:0] reset_byte(input logic [7:0] addr);
    logic [7:0] val;
    case (addr)
      8'h00:   val = 8'h39;
      8'h01:   val = 8'h10;
      8'h02:   val = 8'h06;
      8'h03:   val = 8'h04;
      8'h04:   val = 8'h07;
      8'h06:   val = 8'h80;
      8'h07:   val = 8'h02;
      8'h0B:   val = 8'h06;
      8'h50:   val = 8'hBC;
      8'h51:   val = 8'hFB;
      8'h52:   val = 8'hAD;
      8'h53:   val = 8'hFE;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

// ----- sv/phbsc_front.sv -----
// Front end: classifies each incoming access into a request for the back end,
// applying the function check, dropped offsets and write masks.
// Depends on phbsc_pkg.
`timescale 1ns / 1ps

module phbsc_front (
  input  logic            req_type_i,
  input  logic [2:0]      func_number_i,
  input  logic [7:0]      reg_addr_i,
  input  logic [7:0]      write_data_i,
  output phbsc_pkg::cmd_t cmd_o
);

  logic is_write;
  logic func_zero;
  logic in_rsv;
  logic in_ident;

  assign is_write  = req_type_i;
  assign func_zero = (func_number_i == 3'd0);
  assign in_rsv    = (reg_addr_i >= phbsc_pkg::RSV_LO) && (reg_addr_i <= phbsc_pkg::RSV_HI);
  assign in_ident  = (reg_addr_i <= phbsc_pkg::ID_HI) ||
                     ((reg_addr_i >= phbsc_pkg::HDR_LO) && (reg_addr_i <= phbsc_pkg::HDR_HI)) ||
                     (reg_addr_i == phbsc_pkg::BIST_REG);

  always_comb begin
    cmd_o.addr = reg_addr_i;
    cmd_o.data = write_data_i;
    cmd_o.kind = phbsc_pkg::CMD_NOP;
    if (!is_write) begin
      cmd_o.kind = func_zero ? phbsc_pkg::CMD_READ : phbsc_pkg::CMD_READ_FF;
    end else if (func_zero && !in_rsv && !in_ident) begin
      case (reg_addr_i)
        phbsc_pkg::CMD_LO_REG: begin
          cmd_o.kind = phbsc_pkg::CMD_WRITE;
          cmd_o.data = (write_data_i & phbsc_pkg::CMD_LO_MASK) | phbsc_pkg::CMD_LO_FORCE;
        end
        phbsc_pkg::CMD_HI_REG: begin
          cmd_o.kind = phbsc_pkg::CMD_WRITE;
          cmd_o.data = write_data_i & phbsc_pkg::CMD_HI_MASK;
        end
        phbsc_pkg::STATUS_LO_REG: begin
          cmd_o.kind = phbsc_pkg::CMD_WRITE;
          cmd_o.data = phbsc_pkg::STATUS_LO_FORCE;
        end
        phbsc_pkg::STATUS_HI_REG: begin
          cmd_o.kind = phbsc_pkg::CMD_WRITE;
          cmd_o.data = phbsc_pkg::STATUS_HI_FORCE;
        end
        phbsc_pkg::MODE_REG: begin
          cmd_o.kind = phbsc_pkg::CMD_WRITE_MODE;
        end
        phbsc_pkg::SHADOW_REG: begin
          cmd_o.kind = phbsc_pkg::CMD_WRITE_SHADOW;
        end
        default: begin
          cmd_o.kind = phbsc_pkg::CMD_WRITE;
        end
      endcase
    end
  end

endmodule

// ----- sv/phbsc_cmd_fifo.sv -----
// Two-entry request queue between the front and back ends.
// Depends on phbsc_pkg.
`timescale 1ns / 1ps

module phbsc_cmd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  phbsc_pkg::cmd_t cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output phbsc_pkg::cmd_t cmd_o
);

  phbsc_pkg::cmd_t slot_q [phbsc_pkg::FIFO_DEPTH];
  logic            wptr_q, wptr_d;
  logic            rptr_q, rptr_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (cnt_q == phbsc_pkg::FIFO_DEPTH);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = slot_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = do_push ? ~wptr_q : wptr_q;
    rptr_d = do_pop ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= cmd_i;
    end
  end

endmodule

// ----- sv/phbsc_back.sv -----
// Back end: executes requests against the 256-byte register store, keeps the
// shadow mapping and holds the result register.
// Depends on phbsc_pkg.
`timescale 1ns / 1ps

module phbsc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  phbsc_pkg::cmd_t cmd_i,
  output logic            cmd_pop_o,
  input  logic            pop_i,
  output logic            empty_o,
  output logic [7:0]      read_data_o,
  output logic [3:0]      shadow_read_internal_o,
  output logic [3:0]      shadow_write_internal_o,
  output logic            remapped_o
);

  phbsc_pkg::back_state_e st_q, st_d;

  logic [7:0]   mem_q [256];
  logic [255:0] vld_q;
  logic         vld_rd_q;
  logic [7:0]   mem_rd_q;
  logic [7:0]   rd_addr_q;

  logic [7:0]   mode_q;
  logic [7:0]   shadow_q;
  logic [3:0]   map_rd_q, map_rd_d;
  logic [3:0]   map_wr_q, map_wr_d;

  logic         out_valid_q;
  logic [7:0]   out_data_q;
  logic [3:0]   out_rd_q;
  logic [3:0]   out_wr_q;
  logic         out_remap_q;

  logic         out_free;
  logic         mem_re;
  logic         mem_we;
  logic         out_load;
  logic [7:0]   res_data;
  logic         res_remap;

  assign out_free = !out_valid_q || pop_i;

  always_comb begin
    st_d = st_q;
    case (st_q)
      phbsc_pkg::BK_IDLE: begin
        if (cmd_valid_i && out_free && (cmd_i.kind == phbsc_pkg::CMD_READ)) begin
          st_d = phbsc_pkg::BK_RDWAIT;
        end
      end
      phbsc_pkg::BK_RDWAIT: begin
        st_d = phbsc_pkg::BK_IDLE;
      end
      default: begin
        st_d = phbsc_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_pop_o = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    out_load  = 1'b0;
    res_data  = 8'h00;
    res_remap = 1'b0;
    map_rd_d  = map_rd_q;
    map_wr_d  = map_wr_q;
    case (st_q)
      phbsc_pkg::BK_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.kind)
            phbsc_pkg::CMD_READ: begin
              mem_re = 1'b1;
            end
            phbsc_pkg::CMD_READ_FF: begin
              out_load = 1'b1;
              res_data = phbsc_pkg::NO_FUNC_DATA;
            end
            phbsc_pkg::CMD_WRITE, phbsc_pkg::CMD_WRITE_MODE: begin
              out_load = 1'b1;
              mem_we   = 1'b1;
            end
            phbsc_pkg::CMD_WRITE_SHADOW: begin
              out_load  = 1'b1;
              mem_we    = 1'b1;
              res_remap = ((shadow_q & cmd_i.data) != phbsc_pkg::SHADOW_KEEP);
              if (res_remap) begin
                map_rd_d = mode_q[6] ? cmd_i.data[7:4] : 4'h0;
                map_wr_d = mode_q[5] ? 4'h0 : cmd_i.data[7:4];
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      phbsc_pkg::BK_RDWAIT: begin
        out_load = 1'b1;
        res_data = vld_rd_q ? mem_rd_q : phbsc_pkg::reset_byte(rd_addr_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= phbsc_pkg::BK_IDLE;
      vld_q       <= '0;
      vld_rd_q    <= 1'b0;
      mode_q      <= phbsc_pkg::reset_byte(phbsc_pkg::MODE_REG);
      shadow_q    <= phbsc_pkg::reset_byte(phbsc_pkg::SHADOW_REG);
      map_rd_q    <= 4'h0;
      map_wr_q    <= 4'h0;
      out_valid_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      map_rd_q <= map_rd_d;
      map_wr_q <= map_wr_d;
      if (mem_we) begin
        vld_q[cmd_i.addr] <= 1'b1;
      end
      if (mem_re) begin
        vld_rd_q <= vld_q[cmd_i.addr];
      end
      if (mem_we && (cmd_i.kind == phbsc_pkg::CMD_WRITE_MODE)) begin
        mode_q <= cmd_i.data;
      end
      if (mem_we && (cmd_i.kind == phbsc_pkg::CMD_WRITE_SHADOW)) begin
        shadow_q <= cmd_i.data;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[cmd_i.addr] <= cmd_i.data;
    end
    if (mem_re) begin
      mem_rd_q  <= mem_q[cmd_i.addr];
      rd_addr_q <= cmd_i.addr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q  <= res_data;
      out_rd_q    <= map_rd_d;
      out_wr_q    <= map_wr_d;
      out_remap_q <= res_remap;
    end
  end

  assign empty_o                 = !out_valid_q;
  assign read_data_o             = out_data_q;
  assign shadow_read_internal_o  = out_rd_q;
  assign shadow_write_internal_o = out_wr_q;
  assign remapped_o              = out_remap_q;

  a_rdwait_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == phbsc_pkg::BK_RDWAIT) |-> !out_valid_q)
    else $error("result register occupied while a read is in flight");

  a_rdwait_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == phbsc_pkg::BK_RDWAIT) |=> (out_valid_q && (st_q == phbsc_pkg::BK_IDLE)))
    else $error("read did not complete in one cycle");

  a_pop_has_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (cmd_valid_i && (st_q == phbsc_pkg::BK_IDLE)))
    else $error("request taken from an empty queue or while busy");

  a_remap_map_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_remap |=> ($stable(map_rd_q) && $stable(map_wr_q)))
    else $error("shadow mapping changed without a remap");

endmodule

// ----- sv/pci_host_bridge_shadow_config.sv -----
// Top level of the host bridge configuration space: front classifier,
// request queue and back end with the register store.
// Depends on phbsc_pkg, phbsc_front, phbsc_cmd_fifo and phbsc_back.
//
//   channel   handshake         payload
//   request   push / full       req_type_i, func_number_i, reg_addr_i, write_data_i
//   result    empty / pop       read_data_o, shadow_read_internal_o,
//                               shadow_write_internal_o, remapped_o
//
// A request enters the two-entry queue at the edge it is taken; the back end
// executes it from the next cycle on. Writes and nonzero-function reads finish in the
// idle state; function-0 reads also pass BK_RDWAIT (registered store read port).
// Reset clears the per-byte valid bits at once; unwritten bytes read their
// reset image, so no clearing pass is needed. A held result stalls the back
// end only; the queue keeps taking requests until both entries are full.
`timescale 1ns / 1ps

module pci_host_bridge_shadow_config (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic       req_type_i,
  input  logic [2:0] func_number_i,
  input  logic [7:0] reg_addr_i,
  input  logic [7:0] write_data_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] read_data_o,
  output logic [3:0] shadow_read_internal_o,
  output logic [3:0] shadow_write_internal_o,
  output logic       remapped_o
);

  phbsc_pkg::cmd_t front_cmd;
  phbsc_pkg::cmd_t back_cmd;
  logic            back_valid;
  logic            back_pop;

  phbsc_front u_front (
    .req_type_i    (req_type_i),
    .func_number_i (func_number_i),
    .reg_addr_i    (reg_addr_i),
    .write_data_i  (write_data_i),
    .cmd_o         (front_cmd)
  );

  phbsc_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (back_pop),
    .valid_o (back_valid),
    .cmd_o   (back_cmd)
  );

  phbsc_back u_back (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cmd_valid_i             (back_valid),
    .cmd_i                   (back_cmd),
    .cmd_pop_o               (back_pop),
    .pop_i                   (pop),
    .empty_o                 (empty),
    .read_data_o             (read_data_o),
    .shadow_read_internal_o  (shadow_read_internal_o),
    .shadow_write_internal_o (shadow_write_internal_o),
    .remapped_o              (remapped_o)
  );

endmodule

// ----- sim/tb_pci_host_bridge_shadow_config.sv -----
// Testbench for pci_host_bridge_shadow_config: a directed table of byte accesses, then
// random accesses, scored against fixed row values or an in-bench config store model.
// Depends on phbsc_pkg and the pci_host_bridge_shadow_config RTL.
`timescale 1ns / 1ps

module tb_pci_host_bridge_shadow_config;

  localparam logic       REQ_READ    = 1'b0;
  localparam logic       REQ_WRITE   = 1'b1;
  localparam int         MODE_RD_BIT = 6;
  localparam int         MODE_WR_BIT = 5;
  localparam int         NUM_RANDOM  = 1050;
  localparam int         IDLE_PCT    = 23;
  localparam int         HOLD_AT     = 800;
  localparam int         HOLD_LEN    = 60;
  localparam int         DRAIN       = 20;
  localparam int         LIMIT       = 200000;

  typedef struct packed {
    logic [7:0] read_data;
    logic [3:0] rd_int;
    logic [3:0] wr_int;
    logic       remapped;
  } access_result_t;

  typedef struct {
    logic           req;
    logic [2:0]     func;
    logic [7:0]     addr;
    logic [7:0]     data;
    logic           typed;
    access_result_t want;
  } access_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       push;
  logic       full;
  logic       req_type_i;
  logic [2:0] func_number_i;
  logic [7:0] reg_addr_i;
  logic [7:0] write_data_i;
  logic       empty;
  logic       pop;
  logic [7:0] read_data_o;
  logic [3:0] shadow_read_internal_o;
  logic [3:0] shadow_write_internal_o;
  logic       remapped_o;

  logic [7:0]     cfg_image [256];
  logic [3:0]     map_rd_int;
  logic [3:0]     map_wr_int;
  access_result_t pending_results [$];
  access_row_t    access_table [$];
  int             errors   = 0;
  int             cycle_cnt = 0;
  logic           steady   = 1'b0;

  pci_host_bridge_shadow_config uut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .push                   (push),
    .full                   (full),
    .req_type_i             (req_type_i),
    .func_number_i          (func_number_i),
    .reg_addr_i             (reg_addr_i),
    .write_data_i           (write_data_i),
    .empty                  (empty),
    .pop                    (pop),
    .read_data_o            (read_data_o),
    .shadow_read_internal_o (shadow_read_internal_o),
    .shadow_write_internal_o(shadow_write_internal_o),
    .remapped_o             (remapped_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  task automatic reset_image();
    for (int i = 0; i < 256; i++) cfg_image[i] = 8'h00;
    cfg_image[8'h00] = 8'h39;
    cfg_image[8'h01] = 8'h10;
    cfg_image[8'h02] = 8'h06;
    cfg_image[8'h03] = 8'h04;
    cfg_image[8'h04] = 8'h07;
    cfg_image[8'h06] = 8'h80;
    cfg_image[8'h07] = 8'h02;
    cfg_image[8'h0B] = 8'h06;
    cfg_image[8'h50] = 8'hBC;
    cfg_image[8'h51] = 8'hFB;
    cfg_image[8'h52] = 8'hAD;
    cfg_image[8'h53] = 8'hFE;
    map_rd_int = 4'h0;
    map_wr_int = 4'h0;
  endtask

  task automatic predict_access(input logic req, input logic [2:0] func, input logic [7:0] addr,
                                input logic [7:0] data, output access_result_t res);
    logic       drop;
    logic       remap;
    logic [7:0] val;
    logic [3:0] seg_en;
    logic [7:0] mode;
    remap = 1'b0;
    res.read_data = 8'h00;
    if (req == REQ_WRITE) begin
      drop = (addr >= phbsc_pkg::RSV_LO && addr <= phbsc_pkg::RSV_HI) ||
             (addr <= phbsc_pkg::ID_HI) ||
             (addr >= phbsc_pkg::HDR_LO && addr <= phbsc_pkg::HDR_HI) ||
             (addr == phbsc_pkg::BIST_REG);
      if (func == 3'd0 && !drop) begin
        val = data;
        case (addr)
          phbsc_pkg::CMD_LO_REG:    val = (data & phbsc_pkg::CMD_LO_MASK) |
                                          phbsc_pkg::CMD_LO_FORCE;
          phbsc_pkg::CMD_HI_REG:    val = data & phbsc_pkg::CMD_HI_MASK;
          phbsc_pkg::STATUS_LO_REG: val = phbsc_pkg::STATUS_LO_FORCE;
          phbsc_pkg::STATUS_HI_REG: val = phbsc_pkg::STATUS_HI_FORCE;
          phbsc_pkg::SHADOW_REG:    remap = (cfg_image[phbsc_pkg::SHADOW_REG] & data) !=
                                            phbsc_pkg::SHADOW_KEEP;
          default: ;
        endcase
        cfg_image[addr] = val;
        if (remap) begin
          seg_en = cfg_image[phbsc_pkg::SHADOW_REG][7:4];
          mode = cfg_image[phbsc_pkg::MODE_REG];
          map_rd_int = mode[MODE_RD_BIT] ? seg_en : 4'h0;
          map_wr_int = mode[MODE_WR_BIT] ? 4'h0 : seg_en;
        end
      end
    end else begin
      res.read_data = (func != 3'd0) ? phbsc_pkg::NO_FUNC_DATA : cfg_image[addr];
    end
    res.rd_int = map_rd_int;
    res.wr_int = map_wr_int;
    res.remapped = remap;
  endtask

  task automatic add_row(input logic req, input logic [2:0] func, input logic [7:0] addr,
                         input logic [7:0] data, input logic typed, input logic [7:0] rdata);
    access_row_t row;
    row.req = req;
    row.func = func;
    row.addr = addr;
    row.data = data;
    row.typed = typed;
    row.want = '{read_data: rdata, rd_int: 4'h0, wr_int: 4'h0, remapped: 1'b0};
    access_table.push_back(row);
  endtask

  // Offer one request, hold it until taken, then record what it should return.
  task automatic send_access(input access_row_t row);
    access_result_t res;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    req_type_i <= row.req;
    func_number_i <= row.func;
    reg_addr_i <= row.addr;
    write_data_i <= row.data;
    do @(posedge clk_i); while (full);
    predict_access(row.req, row.func, row.addr, row.data, res);
    pending_results.push_back(row.typed ? row.want : res);
  endtask

  task automatic pick_access(output access_row_t row);
    int kind;
    kind = $urandom_range(99);
    row.typed = 1'b0;
    row.want = '0;
    row.req = 1'($urandom_range(1));
    row.data = 8'($urandom_range(255));
    row.func = ($urandom_range(99) < 85) ? 3'd0 : 3'($urandom_range(7));
    if (kind < 20) begin
      row.addr = phbsc_pkg::SHADOW_REG;
      if ($urandom_range(1)) row.data[7:4] = 4'hF;
    end else if (kind < 32) begin
      row.addr = phbsc_pkg::MODE_REG;
    end else if (kind < 52) begin
      row.addr = 8'($urandom_range(15));
    end else if (kind < 62) begin
      row.addr = 8'($urandom_range(8'h55, phbsc_pkg::RSV_HI));
    end else begin
      row.addr = 8'($urandom_range(255));
    end
  endtask

  initial begin : stimulus
    access_row_t row;
    rst_ni <= 1'b0;
    push <= 1'b0;
    req_type_i <= REQ_READ;
    func_number_i <= 3'd0;
    reg_addr_i <= 8'h00;
    write_data_i <= 8'h00;
    reset_image();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(REQ_READ,  3'd0, 8'h00, 8'h00, 1'b1, 8'h39);
    add_row(REQ_READ,  3'd0, phbsc_pkg::MODE_REG, 8'h00, 1'b1, 8'hFE);
    add_row(REQ_READ,  3'd7, 8'h00, 8'h00, 1'b1, phbsc_pkg::NO_FUNC_DATA);
    add_row(REQ_WRITE, 3'd7, phbsc_pkg::CMD_LO_REG, 8'hFF, 1'b1, 8'h00);
    add_row(REQ_READ,  3'd0, phbsc_pkg::CMD_LO_REG, 8'h00, 1'b1, 8'h07);
    add_row(REQ_WRITE, 3'd0, 8'h00, 8'hFF, 1'b1, 8'h00);
    add_row(REQ_READ,  3'd0, 8'h00, 8'h00, 1'b1, 8'h39);
    add_row(REQ_WRITE, 3'd0, phbsc_pkg::RSV_LO, 8'hAA, 1'b1, 8'h00);
    add_row(REQ_WRITE, 3'd0, phbsc_pkg::RSV_HI, 8'h55, 1'b1, 8'h00);
    add_row(REQ_READ,  3'd0, phbsc_pkg::RSV_HI, 8'h00, 1'b1, 8'h00);
    add_row(REQ_WRITE, 3'd0, 8'h4F, 8'hA5, 1'b1, 8'h00);
    add_row(REQ_READ,  3'd0, 8'h4F, 8'h00, 1'b1, 8'hA5);
    add_row(REQ_WRITE, 3'd0, phbsc_pkg::CMD_LO_REG, 8'hFF, 1'b1, 8'h00);
    add_row(REQ_READ,  3'd0, phbsc_pkg::CMD_LO_REG, 8'h00, 1'b1, 8'h46);
    add_row(REQ_WRITE, 3'd0, phbsc_pkg::CMD_HI_REG, 8'hFF, 1'b1, 8'h00);
    add_row(REQ_READ,  3'd0, phbsc_pkg::CMD_HI_REG, 8'h00, 1'b1, 8'h01);
    add_row(REQ_WRITE, 3'd0, phbsc_pkg::STATUS_LO_REG, 8'hFF, 1'b1, 8'h00);
    add_row(REQ_READ,  3'd0, phbsc_pkg::STATUS_LO_REG, 8'h00, 1'b1, 8'h00);
    add_row(REQ_WRITE, 3'd0, phbsc_pkg::STATUS_HI_REG, 8'h00, 1'b1, 8'h00);
    add_row(REQ_READ,  3'd0, phbsc_pkg::STATUS_HI_REG, 8'h00, 1'b1, 8'h02);
    add_row(REQ_WRITE, 3'd0, phbsc_pkg::BIST_REG, 8'h12, 1'b0, 8'h00);
    add_row(REQ_READ,  3'd0, phbsc_pkg::BIST_REG, 8'h00, 1'b0, 8'h00);
    add_row(REQ_WRITE, 3'd0, phbsc_pkg::SHADOW_REG, 8'hF0, 1'b0, 8'h00);
    add_row(REQ_WRITE, 3'd0, phbsc_pkg::SHADOW_REG, 8'hF0, 1'b0, 8'h00);
    add_row(REQ_WRITE, 3'd0, phbsc_pkg::MODE_REG, 8'h00, 1'b0, 8'h00);
    add_row(REQ_WRITE, 3'd0, phbsc_pkg::SHADOW_REG, 8'h30, 1'b0, 8'h00);
    add_row(REQ_READ,  3'd0, phbsc_pkg::SHADOW_REG, 8'h00, 1'b0, 8'h00);
    foreach (access_table[i]) send_access(access_table[i]);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      steady = (n >= 500 && n < 750);
      pick_access(row);
      send_access(row);
    end
    steady = 1'b0;
    push <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : result_sink
    access_result_t got;
    access_result_t want;
    int hold_left;
    hold_left = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        got = {read_data_o, shadow_read_internal_o, shadow_write_internal_o, remapped_o};
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t unexpected result: expected none, actual %h", $time, got);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            errors++;
            $display({"%0t mismatch: expected rd=%h ri=%h wi=%h rm=%b, ",
                      "actual rd=%h ri=%h wi=%h rm=%b"},
                     $time, want.read_data, want.rd_int, want.wr_int, want.remapped,
                     got.read_data, got.rd_int, got.wr_int, got.remapped);
          end
        end
      end
      if (cycle_cnt == HOLD_AT) hold_left = HOLD_LEN;
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < LIMIT) @(posedge clk_i);
    $display("Some tests failed");
    $finish;
  end

endmodule
